// ----- sv/iepf_pkg.sv -----
// iepf_pkg: constants, result type and field widths for the icmp echo parity packet filter
// no dependencies; used by every other file of the block except iepf_if
package iepf_pkg;

  localparam int MAX_VLAN_TAGS = 4;
  localparam int VLAN_CNT_W = (MAX_VLAN_TAGS < 1) ? 1 : $clog2(MAX_VLAN_TAGS + 1);

  localparam logic [15:0] TPID_CTAG  = 16'h8100;
  localparam logic [15:0] TPID_STAG  = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP   = 8'd1;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] ECHO_REQ_V4  = 8'd8;
  localparam logic [7:0] ECHO_REQ_V6  = 8'd128;

  localparam logic [7:0] ETH_HDR_LEN  = 8'd14;
  localparam logic [7:0] VLAN_TAG_LEN = 8'd4;
  localparam logic [6:0] IPV4_MIN_LEN = 7'd20;
  localparam logic [7:0] IPV6_HDR_LEN = 8'd40;
  localparam logic [7:0] ICMP_HDR_LEN = 8'd8;

  localparam logic [1:0] NET_OTHER = 2'd0;
  localparam logic [1:0] NET_IPV4  = 2'd1;
  localparam logic [1:0] NET_IPV6  = 2'd2;

  typedef struct packed {
    logic       verdict;
    logic [1:0] network_kind;
    logic       echo_seen;
    logic [2:0] tags_stripped;
  } result_t;

endpackage

// ----- sv/iepf_if.sv -----
// iepf_in_if / iepf_out_if: valid/ready channels for packet bytes and verdict words
// depends on nothing; payload widths follow the block's field widths
interface iepf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface iepf_out_if;
  logic       valid;
  logic       ready;
  logic       verdict;
  logic [1:0] network_kind;
  logic       echo_seen;
  logic [2:0] tags_stripped;

  modport source (output valid, output verdict, output network_kind, output echo_seen,
                  output tags_stripped, input ready);
  modport sink   (input valid, input verdict, input network_kind, input echo_seen,
                  input tags_stripped, output ready);
endinterface

// ----- sv/icmp_echo_parity_packet_filter.sv -----
// Packet filter for Ethernet with up to four VLAN tags, IPv4 or IPv6, and ICMP echo
// parity. Bytes arrive one per word with the last byte marked; one verdict word comes
// out per packet, in the cycle after the final byte is accepted. A byte is taken every
// cycle while the output register is empty or being read; while a verdict word waits
// there and the sink holds off, every input byte is held until the sink takes it.
// Packets are dropped when the ethertype is not IP or the frame ends before it, or when
// an echo request carries an even sequence number; all else passes.
// depends on iepf_pkg, iepf_if, iepf_parser, iepf_out_reg
module icmp_echo_parity_packet_filter (
  input  logic        clk,
  input  logic        rst,
  iepf_in_if.sink     pkt_in,
  iepf_out_if.source  verdict_out
);

  iepf_pkg::result_t result;
  logic              can_load;
  logic              accept;

  assign pkt_in.ready = can_load;
  assign accept       = pkt_in.valid && pkt_in.ready;

  iepf_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (pkt_in.data_byte),
    .end_of_packet (pkt_in.end_of_packet),
    .result        (result)
  );

  iepf_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && pkt_in.end_of_packet),
    .result   (result),
    .can_load (can_load),
    .tx       (verdict_out)
  );

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    (verdict_out.valid && !verdict_out.ready) |-> !pkt_in.ready)
    else $error("byte taken while verdict stalled");

  a_eop_gives_word: assert property (@(posedge clk) disable iff (rst)
    (pkt_in.valid && pkt_in.ready && pkt_in.end_of_packet) |=> verdict_out.valid)
    else $error("final byte did not produce a verdict");

  a_non_ip_drops: assert property (@(posedge clk) disable iff (rst)
    (verdict_out.valid && verdict_out.network_kind == iepf_pkg::NET_OTHER)
      |-> verdict_out.verdict)
    else $error("non ip packet passed");

  a_echo_needs_ip: assert property (@(posedge clk) disable iff (rst)
    (verdict_out.valid && verdict_out.echo_seen)
      |-> (verdict_out.network_kind != iepf_pkg::NET_OTHER))
    else $error("echo seen without ip header");

endmodule

// ----- sv/iepf_parser.sv -----
// iepf_parser: per-packet header parse state, updated once for every accepted byte
// depends on iepf_pkg; gives the verdict word that the final byte produces
module iepf_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              end_of_packet,
  output iepf_pkg::result_t result
);

  localparam logic [2:0] PH_ETH  = 3'd0;
  localparam logic [2:0] PH_VLAN = 3'd1;
  localparam logic [2:0] PH_IPV4 = 3'd2;
  localparam logic [2:0] PH_IPV6 = 3'd3;
  localparam logic [2:0] PH_ICMP = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam int VW = iepf_pkg::VLAN_CNT_W;

  logic [2:0]    parse_phase, parse_phase_next;
  logic [7:0]    byte_offset, byte_offset_next;
  logic [15:0]   type_shift, type_shift_next;
  logic [VW-1:0] vlan_count, vlan_count_next;
  logic [5:0]    ip_header_len, ip_header_len_next;
  logic [7:0]    transport_proto, transport_proto_next;
  logic [7:0]    icmp_start, icmp_start_next;
  logic          echo_flag, echo_flag_next;
  logic          drop_flag, drop_flag_next;
  logic [1:0]    net_kind, net_kind_next;
  logic          type_is_echo, type_is_echo_next;

  logic [7:0]  l3;
  logic [7:0]  rel;
  logic [7:0]  rel_icmp;
  logic [8:0]  rel_plus1;
  logic [15:0] shifted;
  logic        do_resolve;
  logic        is_vlan;
  logic [7:0]  echo_code;

  always_comb begin
    l3        = iepf_pkg::ETH_HDR_LEN + 8'({vlan_count, 2'b00});
    rel       = byte_offset - l3;
    rel_icmp  = byte_offset - icmp_start;
    rel_plus1 = {1'b0, rel} + 9'd1;
    shifted   = {type_shift[7:0], data_byte};
    echo_code = (net_kind == iepf_pkg::NET_IPV4) ? iepf_pkg::ECHO_REQ_V4
                                                 : iepf_pkg::ECHO_REQ_V6;

    parse_phase_next     = parse_phase;
    type_shift_next      = type_shift;
    vlan_count_next      = vlan_count;
    ip_header_len_next   = ip_header_len;
    transport_proto_next = transport_proto;
    icmp_start_next      = icmp_start;
    echo_flag_next       = echo_flag;
    drop_flag_next       = drop_flag;
    net_kind_next        = net_kind;
    type_is_echo_next    = type_is_echo;
    do_resolve           = 1'b0;

    unique case (parse_phase)
      PH_ETH: begin
        if (byte_offset >= 8'd12) type_shift_next = shifted;
        if (byte_offset == iepf_pkg::ETH_HDR_LEN - 8'd1) do_resolve = 1'b1;
      end
      PH_VLAN: begin
        if (rel >= 8'd2) type_shift_next = shifted;
        if (rel == iepf_pkg::VLAN_TAG_LEN - 8'd1) begin
          vlan_count_next = vlan_count + VW'(1);
          do_resolve      = 1'b1;
        end
      end
      PH_IPV4: begin
        if (rel == 8'd0) begin
          ip_header_len_next = {data_byte[3:0], 2'b00};
          if ({1'b0, data_byte[3:0], 2'b00} < iepf_pkg::IPV4_MIN_LEN) begin
            parse_phase_next = PH_DONE;
          end
        end else begin
          if (rel == 8'd9) transport_proto_next = data_byte;
          if (rel_plus1 == {3'b000, ip_header_len}) begin
            if (transport_proto == iepf_pkg::PROTO_ICMP) begin
              parse_phase_next = PH_ICMP;
              icmp_start_next  = byte_offset + 8'd1;
            end else begin
              parse_phase_next = PH_DONE;
            end
          end
        end
      end
      PH_IPV6: begin
        if (rel == 8'd6) transport_proto_next = data_byte;
        if (rel == iepf_pkg::IPV6_HDR_LEN - 8'd1) begin
          if (transport_proto == iepf_pkg::PROTO_ICMPV6) begin
            parse_phase_next = PH_ICMP;
            icmp_start_next  = byte_offset + 8'd1;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
      end
      PH_ICMP: begin
        if (rel_icmp == 8'd0) type_is_echo_next = (data_byte == echo_code);
        if (rel_icmp == iepf_pkg::ICMP_HDR_LEN - 8'd1) begin
          if (type_is_echo) begin
            echo_flag_next = 1'b1;
            if (!data_byte[0]) drop_flag_next = 1'b1;
          end
          parse_phase_next = PH_DONE;
        end
      end
      default: ;
    endcase

    is_vlan = (type_shift_next == iepf_pkg::TPID_CTAG) ||
              (type_shift_next == iepf_pkg::TPID_STAG);
    if (do_resolve) begin
      priority if (is_vlan && (32'(vlan_count_next) < iepf_pkg::MAX_VLAN_TAGS)) begin
        parse_phase_next = PH_VLAN;
      end else if (type_shift_next == iepf_pkg::ETYPE_IPV4) begin
        net_kind_next    = iepf_pkg::NET_IPV4;
        drop_flag_next   = 1'b0;
        parse_phase_next = PH_IPV4;
      end else if (type_shift_next == iepf_pkg::ETYPE_IPV6) begin
        net_kind_next    = iepf_pkg::NET_IPV6;
        drop_flag_next   = 1'b0;
        parse_phase_next = PH_IPV6;
      end else begin
        drop_flag_next   = 1'b1;
        parse_phase_next = PH_DONE;
      end
    end

    byte_offset_next = (byte_offset == 8'hFF) ? byte_offset : byte_offset + 8'd1;

    result.verdict       = drop_flag_next;
    result.network_kind  = net_kind_next;
    result.echo_seen     = echo_flag_next;
    result.tags_stripped = (32'(vlan_count_next) > 32'd7) ? 3'd7 : 3'(vlan_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_packet)) begin
      parse_phase     <= PH_ETH;
      byte_offset     <= '0;
      type_shift      <= '0;
      vlan_count      <= '0;
      ip_header_len   <= '0;
      transport_proto <= '0;
      icmp_start      <= '0;
      echo_flag       <= 1'b0;
      drop_flag       <= 1'b1;
      net_kind        <= iepf_pkg::NET_OTHER;
      type_is_echo    <= 1'b0;
    end else if (accept) begin
      parse_phase     <= parse_phase_next;
      byte_offset     <= byte_offset_next;
      type_shift      <= type_shift_next;
      vlan_count      <= vlan_count_next;
      ip_header_len   <= ip_header_len_next;
      transport_proto <= transport_proto_next;
      icmp_start      <= icmp_start_next;
      echo_flag       <= echo_flag_next;
      drop_flag       <= drop_flag_next;
      net_kind        <= net_kind_next;
      type_is_echo    <= type_is_echo_next;
    end
  end

endmodule

// ----- sv/iepf_out_reg.sv -----
// iepf_out_reg: result register holding one verdict word until the sink takes it
// depends on iepf_pkg and iepf_out_if
module iepf_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  iepf_pkg::result_t result,
  output logic              can_load,
  iepf_out_if.source        tx
);

  logic              full;
  iepf_pkg::result_t held;

  assign can_load = !full || tx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (tx.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) held <= result;
  end

  assign tx.valid         = full;
  assign tx.verdict       = held.verdict;
  assign tx.network_kind  = held.network_kind;
  assign tx.echo_seen     = held.echo_seen;
  assign tx.tags_stripped = held.tags_stripped;

endmodule

// ----- tb/icmp_echo_parity_packet_filter_tb.sv -----
// testbench for icmp_echo_parity_packet_filter: directed and random frames, checked word by word
// against a header-parsing predictor; depends on iepf_pkg, iepf_if and the block itself
module icmp_echo_parity_packet_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [2:0] {
    HDR_ETH, HDR_VLAN, HDR_IPV4, HDR_IPV6, HDR_ICMP, HDR_DONE
  } hdr_stage_t;

  logic clk = 1'b0;
  logic rst;

  iepf_in_if  pkt_in();
  iepf_out_if verdict_out();

  icmp_echo_parity_packet_filter uut (
    .clk         (clk),
    .rst         (rst),
    .pkt_in      (pkt_in),
    .verdict_out (verdict_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  hdr_stage_t  stage;
  logic [7:0]  pos;
  logic [15:0] ethertype_acc;
  int          tags_seen;
  logic [7:0]  ihl_len;
  logic [7:0]  l4_proto;
  logic [7:0]  icmp_base;
  logic        echo_hit;
  logic        drop_pkt;
  logic [1:0]  net_type;
  logic        echo_type_hit;

  iepf_pkg::result_t verdict_q[$];
  logic [7:0]  frame[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          cycle_cnt = 0;
  bit          idle_in = 1'b1;
  bit          idle_out = 1'b1;
  bit          hold_out = 1'b0;

  function void start_new_packet();
    stage = HDR_ETH;
    pos = '0;
    ethertype_acc = '0;
    tags_seen = 0;
    ihl_len = '0;
    l4_proto = '0;
    icmp_base = '0;
    echo_hit = 1'b0;
    drop_pkt = 1'b1;
    net_type = iepf_pkg::NET_OTHER;
    echo_type_hit = 1'b0;
  endfunction

  function void resolve_ethertype();
    if ((ethertype_acc == iepf_pkg::TPID_CTAG || ethertype_acc == iepf_pkg::TPID_STAG) &&
        tags_seen < iepf_pkg::MAX_VLAN_TAGS) begin
      stage = HDR_VLAN;
    end else if (ethertype_acc == iepf_pkg::ETYPE_IPV4) begin
      net_type = iepf_pkg::NET_IPV4;
      drop_pkt = 1'b0;
      stage = HDR_IPV4;
    end else if (ethertype_acc == iepf_pkg::ETYPE_IPV6) begin
      net_type = iepf_pkg::NET_IPV6;
      drop_pkt = 1'b0;
      stage = HDR_IPV6;
    end else begin
      drop_pkt = 1'b1;
      stage = HDR_DONE;
    end
  endfunction

  task automatic filter_byte(input logic [7:0] b, input logic last);
    int l3;
    int rel;
    iepf_pkg::result_t r;
    l3 = int'(iepf_pkg::ETH_HDR_LEN) + int'(iepf_pkg::VLAN_TAG_LEN) * tags_seen;
    case (stage)
      HDR_ETH: begin
        if (pos >= 8'd12) ethertype_acc = {ethertype_acc[7:0], b};
        if (pos == iepf_pkg::ETH_HDR_LEN - 8'd1) resolve_ethertype();
      end
      HDR_VLAN: begin
        rel = int'(pos) - l3;
        if (rel >= 2) ethertype_acc = {ethertype_acc[7:0], b};
        if (rel == int'(iepf_pkg::VLAN_TAG_LEN) - 1) begin
          tags_seen++;
          resolve_ethertype();
        end
      end
      HDR_IPV4: begin
        rel = int'(pos) - l3;
        if (rel == 0) ihl_len = {2'b00, b[3:0], 2'b00};
        if (rel == 0 && ihl_len < iepf_pkg::IPV4_MIN_LEN) begin
          stage = HDR_DONE;
        end else begin
          if (rel == 9) l4_proto = b;
          if (rel + 1 == int'(ihl_len)) begin
            if (l4_proto == iepf_pkg::PROTO_ICMP) begin
              stage = HDR_ICMP;
              icmp_base = pos + 8'd1;
            end else begin
              stage = HDR_DONE;
            end
          end
        end
      end
      HDR_IPV6: begin
        rel = int'(pos) - l3;
        if (rel == 6) l4_proto = b;
        if (rel == int'(iepf_pkg::IPV6_HDR_LEN) - 1) begin
          if (l4_proto == iepf_pkg::PROTO_ICMPV6) begin
            stage = HDR_ICMP;
            icmp_base = pos + 8'd1;
          end else begin
            stage = HDR_DONE;
          end
        end
      end
      HDR_ICMP: begin
        rel = int'(pos) - int'(icmp_base);
        if (rel == 0)
          echo_type_hit = (b == ((net_type == iepf_pkg::NET_IPV4) ? iepf_pkg::ECHO_REQ_V4
                                                                   : iepf_pkg::ECHO_REQ_V6));
        if (rel == int'(iepf_pkg::ICMP_HDR_LEN) - 1) begin
          if (echo_type_hit) begin
            echo_hit = 1'b1;
            if (!b[0]) drop_pkt = 1'b1;
          end
          stage = HDR_DONE;
        end
      end
      default: ;
    endcase
    if (pos != 8'hFF) pos = pos + 8'd1;
    if (last) begin
      r.verdict = drop_pkt;
      r.network_kind = net_type;
      r.echo_seen = echo_hit;
      r.tags_stripped = (tags_seen > 7) ? 3'd7 : 3'(tags_seen);
      verdict_q.push_back(r);
      start_new_packet();
    end
  endtask

  // called just after a rising edge; returns at the edge that accepts the word
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_in && $urandom_range(0, 5) == 0) begin
      pkt_in.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    pkt_in.valid <= 1'b1;
    pkt_in.data_byte <= b;
    pkt_in.end_of_packet <= last;
    @(posedge clk);
    while (!pkt_in.ready) @(posedge clk);
    bytes_sent++;
    filter_byte(b, last);
  endtask

  // keep = 0 sends the whole frame, otherwise only its first keep bytes
  task automatic send_frame(input int keep);
    int n;
    n = (keep == 0 || keep > frame.size()) ? frame.size() : keep;
    for (int i = 0; i < n; i++) send_byte(frame[i], i == n - 1);
  endtask

  task automatic build_frame(input int ntags, input logic [15:0] etype, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [7:0] icmp_type,
                             input logic [15:0] seq, input int trailer);
    int hlen;
    bit with_icmp;
    logic [15:0] tpid;
    frame.delete();
    repeat (12) frame.push_back(8'($urandom));
    for (int t = 0; t < ntags; t++) begin
      tpid = ($urandom_range(0, 1) == 1) ? iepf_pkg::TPID_STAG : iepf_pkg::TPID_CTAG;
      frame.push_back(tpid[15:8]);
      frame.push_back(tpid[7:0]);
      frame.push_back(8'($urandom));
      frame.push_back(8'($urandom));
    end
    frame.push_back(etype[15:8]);
    frame.push_back(etype[7:0]);
    with_icmp = 1'b0;
    if (etype == iepf_pkg::ETYPE_IPV4) begin
      hlen = (ihl < 4'd5) ? 20 : 4 * int'(ihl);
      for (int i = 0; i < hlen; i++) begin
        if (i == 0) frame.push_back({4'h4, ihl});
        else if (i == 9) frame.push_back(proto);
        else frame.push_back(8'($urandom));
      end
      with_icmp = (ihl >= 4'd5) && (proto == iepf_pkg::PROTO_ICMP);
    end else if (etype == iepf_pkg::ETYPE_IPV6) begin
      for (int i = 0; i < int'(iepf_pkg::IPV6_HDR_LEN); i++) begin
        if (i == 0) frame.push_back({4'h6, 4'($urandom)});
        else if (i == 6) frame.push_back(proto);
        else frame.push_back(8'($urandom));
      end
      with_icmp = (proto == iepf_pkg::PROTO_ICMPV6);
    end
    if (with_icmp) begin
      frame.push_back(icmp_type);
      repeat (5) frame.push_back(8'($urandom));
      frame.push_back(seq[15:8]);
      frame.push_back(seq[7:0]);
    end
    repeat (trailer) frame.push_back(8'($urandom));
  endtask

  task automatic test_directed_packets();
    // echo parity on both ip versions
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0001, 0);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'hFFFE, 3);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV6, 4'd5, iepf_pkg::PROTO_ICMPV6, iepf_pkg::ECHO_REQ_V6,
                16'h0000, 0);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV6, 4'd5, iepf_pkg::PROTO_ICMPV6, iepf_pkg::ECHO_REQ_V6,
                16'hFFFF, 2);
    send_frame(0);
    // non-echo types and mismatched protocols
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, 8'd0, 16'h0002, 0);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V6,
                16'h0004, 0);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV6, 4'd5, iepf_pkg::PROTO_ICMPV6, iepf_pkg::ECHO_REQ_V4,
                16'h0006, 0);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMPV6, iepf_pkg::ECHO_REQ_V4,
                16'h0000, 8);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV6, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0000, 8);
    send_frame(0);
    // non-ip ethertype and short ethernet header
    build_frame(0, 16'h1234, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4, 16'h0000, 4);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0000, 0);
    send_frame(1);
    send_frame(13);
    send_frame(14);
    // vlan stacks: full, two tags on ipv6, one too many, cut just after a tag
    build_frame(4, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h1000, 0);
    send_frame(0);
    build_frame(2, iepf_pkg::ETYPE_IPV6, 4'd5, iepf_pkg::PROTO_ICMPV6, iepf_pkg::ECHO_REQ_V6,
                16'h1001, 0);
    send_frame(0);
    build_frame(5, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0001, 0);
    send_frame(0);
    build_frame(1, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0001, 0);
    send_frame(16);
    // ihl extremes and cut-short ip / icmp headers
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd0, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0000, 0);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd4, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0000, 10);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd15, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h8000, 0);
    send_frame(0);
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                16'h0000, 0);
    send_frame(24);
    send_frame(41);
    // all-zero and all-ones bytes
    frame.delete();
    repeat (20) frame.push_back(8'h00);
    send_frame(0);
    frame.delete();
    repeat (20) frame.push_back(8'hFF);
    send_frame(0);
    // long frame, offset counter saturates
    build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, 8'd6, 8'd0, 16'h0000, 225);
    send_frame(0);
  endtask

  task automatic test_random_traffic(input int byte_goal, input int frame_goal);
    int start_bytes;
    int n;
    int r;
    int ntags;
    logic [15:0] etype;
    logic [3:0] ihl;
    logic [7:0] proto;
    logic [7:0] itype;
    start_bytes = bytes_sent;
    n = 0;
    while (bytes_sent - start_bytes < byte_goal || n < frame_goal) begin
      r = $urandom_range(0, 9);
      ntags = (r < 5) ? 0 : (r < 7) ? 1 : (r < 8) ? 2 :
              (r < 9) ? int'($urandom_range(3, 4)) : 5;
      r = $urandom_range(0, 9);
      etype = (r < 5) ? iepf_pkg::ETYPE_IPV4 : (r < 9) ? iepf_pkg::ETYPE_IPV6 : 16'($urandom);
      if ($urandom_range(0, 7) == 0) ihl = 4'($urandom_range(0, 4));
      else if ($urandom_range(0, 3) == 0) ihl = 4'($urandom_range(6, 15));
      else ihl = 4'd5;
      if ($urandom_range(0, 7) == 0) proto = 8'($urandom);
      else proto = (etype == iepf_pkg::ETYPE_IPV6) ? iepf_pkg::PROTO_ICMPV6
                                                    : iepf_pkg::PROTO_ICMP;
      if ($urandom_range(0, 3) == 0) itype = 8'($urandom);
      else itype = (etype == iepf_pkg::ETYPE_IPV6) ? iepf_pkg::ECHO_REQ_V6
                                                    : iepf_pkg::ECHO_REQ_V4;
      build_frame(ntags, etype, ihl, proto, itype, 16'($urandom), $urandom_range(0, 6));
      if ($urandom_range(0, 15) == 0) begin
        frame.delete();
        repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
      end
      if ($urandom_range(0, 7) == 0) send_frame($urandom_range(1, frame.size()));
      else send_frame(0);
      n++;
    end
  endtask

  task automatic test_output_backpressure();
    hold_out = 1'b1;
    for (int i = 0; i < 1; i++) begin
      build_frame(0, iepf_pkg::ETYPE_IPV4, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                  16'($urandom), 0);
      send_frame(0);
      build_frame(0, 16'h0806, 4'd5, iepf_pkg::PROTO_ICMP, iepf_pkg::ECHO_REQ_V4,
                  16'h0000, 0);
      send_frame(3);
    end
  endtask

  task automatic test_line_rate();
    idle_in = 1'b0;
    idle_out = 1'b0;
    test_random_traffic(60, 1);
  endtask

  initial begin : sink_ready
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    verdict_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_left = HOLD_CYCLES;
        hold_out = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        verdict_out.ready <= 1'b0;
      end else if (idle_out && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        verdict_out.ready <= 1'b0;
      end else begin
        verdict_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    iepf_pkg::result_t want;
    if (!rst && verdict_out.valid && verdict_out.ready) begin
      if (verdict_q.size() == 0) begin
        $error("verdict word with no packet pending");
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict_out.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, verdict_out.verdict);
          errors++;
        end
        if (verdict_out.network_kind !== want.network_kind) begin
          $error("network_kind: expected %0d, got %0d", want.network_kind,
                 verdict_out.network_kind);
          errors++;
        end
        if (verdict_out.echo_seen !== want.echo_seen) begin
          $error("echo_seen: expected %0d, got %0d", want.echo_seen, verdict_out.echo_seen);
          errors++;
        end
        if (verdict_out.tags_stripped !== want.tags_stripped) begin
          $error("tags_stripped: expected %0d, got %0d", want.tags_stripped,
                 verdict_out.tags_stripped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    start_new_packet();
    rst <= 1'b1;
    pkt_in.valid <= 1'b0;
    pkt_in.data_byte <= 8'h00;
    pkt_in.end_of_packet <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_packets();
    test_random_traffic(60, 1);
    test_output_backpressure();
    test_line_rate();
    pkt_in.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
